// ===== src/yhr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIQ hue rotation package
// Shared register map, configuration struct, color matrices and the
// coefficient quantizer used by the hue rotation pixel pipeline.
// ----------------------------------------------------------------------------
package yhr_pkg;

    localparam int ANGLE_FRAC_BITS = 14;
    localparam int ANGLE_W         = 16;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // Word index of each register, taken from paddr[2].
    localparam logic REG_COS_ANGLE = 1'b0;
    localparam logic REG_SIN_ANGLE = 1'b1;

    localparam logic signed [ANGLE_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] SIN_RESET = 16'sd0;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] cos_angle;
        logic signed [ANGLE_W-1:0] sin_angle;
    } angle_cfg_t;

    // Matrix coefficients in thousandths, row major.
    localparam int FWD_MILLI [9] = '{299, 587, 114, 596, -274, -321, 211, -523, 311};
    localparam int INV_MILLI [9] = '{1000, 956, 621, 1000, -272, -647, 1000, -1107, 1705};

    // Rounds milli / 1000 to frac_bits fractional bits, ties away from zero.
    function automatic longint to_coef(input int milli, input int frac_bits);
        longint scale;
        longint mag;
        scale = longint'(1) <<< frac_bits;
        if (milli >= 0) begin
            mag = longint'(milli);
            return (mag * scale + 64'sd500) / 1000;
        end
        mag = -longint'(milli);
        return -((mag * scale + 64'sd500) / 1000);
    endfunction

endpackage

// ===== src/yhr_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIQ hue rotation configuration registers
// APB-style slave holding the cosine and sine of the hue angle.
// ----------------------------------------------------------------------------
module yhr_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yhr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [yhr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [yhr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output yhr_pkg::angle_cfg_t               cfg
);

    yhr_pkg::angle_cfg_t cfg_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_angle <= yhr_pkg::COS_RESET;
            cfg_reg.sin_angle <= yhr_pkg::SIN_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                yhr_pkg::REG_COS_ANGLE: cfg_reg.cos_angle <= pwdata[yhr_pkg::ANGLE_W-1:0];
                yhr_pkg::REG_SIN_ANGLE: cfg_reg.sin_angle <= pwdata[yhr_pkg::ANGLE_W-1:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Reads return the value sign-extended to the bus width.
    always_comb
    begin
        case (paddr[2])
            yhr_pkg::REG_COS_ANGLE:
                prdata = yhr_pkg::APB_DATA_W'(cfg_reg.cos_angle);
            yhr_pkg::REG_SIN_ANGLE:
                prdata = yhr_pkg::APB_DATA_W'(cfg_reg.sin_angle);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== src/yiq_hue_rotate_pixel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIQ hue rotation pixel pipeline
// Converts an RGB888 pixel to YIQ, rotates the I/Q pair by a programmable
// angle and converts back to RGB888 with saturation.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                   Direction  Purpose
//   --------  ----------------------------------------  ---------  ---------------
//   pixel in  in_valid/in_ready, red/green/blue_in      input      source pixels
//   pixel out out_valid/out_ready, red/green/blue_out   output     rotated pixels
//   config    psel/penable/pwrite/paddr/pwdata/prdata   slave      cos/sin angle
//
// Each pixel passes through five register stages before its result can be
// taken: forward matrix, rotation products, rotation sums, inverse products
// and inverse sums with clamping. One pixel can be accepted in every cycle
// unless a stalled output has filled the stages.
// Reset clears the stage valid bits and loads cos = 1.0, sin = 0.0.
// A stalled output only holds the stages that are full; empty stages keep
// filling, so no transaction is lost or duplicated.
//
module yiq_hue_rotate_pixel_top #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Pixel input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    // Pixel output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        red_out,
    output logic [7:0]                        green_out,
    output logic [7:0]                        blue_out,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yhr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [yhr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [yhr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int F    = COEF_FRAC_BITS;
    localparam int AF   = yhr_pkg::ANGLE_FRAC_BITS;
    localparam int AW   = yhr_pkg::ANGLE_W;
    localparam int NSTG = 5;

    // Coefficients are below 2.0 in magnitude.
    localparam int CW  = F + 2;
    // Forward products and sums; Y, I and Q stay within +-2^(F+9).
    localparam int FAW = CW + 11;
    localparam int YW  = F + 10;
    // Rotation products and their sums.
    localparam int PW  = AW + YW;
    localparam int SW  = PW + 1;
    localparam int RW  = SW - AF;
    // Inverse products and sums.
    localparam int DW  = CW + RW;
    localparam int EW  = DW + 2;
    localparam int VW  = EW - F;

    localparam logic signed [SW-1:0] HALF_ROT = SW'(1) <<< (AF - 1);
    localparam logic signed [EW-1:0] HALF_INV = EW'(1) <<< (F - 1);

    localparam logic signed [CW-1:0] FWD_C [9] = '{
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[0], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[1], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[2], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[3], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[4], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[5], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[6], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[7], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::FWD_MILLI[8], F))
    };

    localparam logic signed [CW-1:0] INV_C [9] = '{
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[0], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[1], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[2], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[3], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[4], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[5], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[6], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[7], F)),
        CW'(yhr_pkg::to_coef(yhr_pkg::INV_MILLI[8], F))
    };

    yhr_pkg::angle_cfg_t cfg;

    yhr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Stage control. A stage loads when it is empty or when the stage
    // after it moves on in the same cycle.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] stg_valid_reg;
    logic [NSTG-1:0] stg_en;

    always_comb
    begin
        stg_en[NSTG-1] = !stg_valid_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stg_en[k] = !stg_valid_reg[k] || stg_en[k + 1];
        end
    end

    assign in_ready  = stg_en[0];
    assign out_valid = stg_valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (stg_en[k])
                begin
                    stg_valid_reg[k] <= (k == 0) ? in_valid : stg_valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: forward matrix, RGB to YIQ.
    // ------------------------------------------------------------------
    logic signed [FAW-1:0] ch_ext [3];
    logic signed [FAW-1:0] fwd_acc [3];
    logic signed [YW-1:0]  yiq_reg [3];

    assign ch_ext[0] = FAW'($signed({1'b0, red_in}));
    assign ch_ext[1] = FAW'($signed({1'b0, green_in}));
    assign ch_ext[2] = FAW'($signed({1'b0, blue_in}));

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            fwd_acc[r] = FAW'(FWD_C[r * 3 + 0]) * ch_ext[0]
                       + FAW'(FWD_C[r * 3 + 1]) * ch_ext[1]
                       + FAW'(FWD_C[r * 3 + 2]) * ch_ext[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                yiq_reg[r] <= fwd_acc[r][YW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation products.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] cos_i_reg;
    logic signed [PW-1:0] sin_q_reg;
    logic signed [PW-1:0] sin_i_reg;
    logic signed [PW-1:0] cos_q_reg;
    logic signed [YW-1:0] y_b_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            cos_i_reg <= PW'(cfg.cos_angle) * PW'(yiq_reg[1]);
            sin_q_reg <= PW'(cfg.sin_angle) * PW'(yiq_reg[2]);
            sin_i_reg <= PW'(cfg.sin_angle) * PW'(yiq_reg[1]);
            cos_q_reg <= PW'(cfg.cos_angle) * PW'(yiq_reg[2]);
            y_b_reg   <= yiq_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotation sums, rounded half up to F fractional bits.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] rot_i_sum;
    logic signed [SW-1:0] rot_q_sum;
    logic signed [YW-1:0] y_c_reg;
    logic signed [RW-1:0] rot_i_reg;
    logic signed [RW-1:0] rot_q_reg;

    assign rot_i_sum = SW'(cos_i_reg) - SW'(sin_q_reg) + HALF_ROT;
    assign rot_q_sum = SW'(sin_i_reg) + SW'(cos_q_reg) + HALF_ROT;

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            rot_i_reg <= rot_i_sum[SW-1:AF];
            rot_q_reg <= rot_q_sum[SW-1:AF];
            y_c_reg   <= y_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: inverse matrix products.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] inv_prod_reg [9];

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            for (int r = 0; r < 3; r++)
            begin
                inv_prod_reg[r * 3 + 0] <= DW'(INV_C[r * 3 + 0]) * DW'(y_c_reg);
                inv_prod_reg[r * 3 + 1] <= DW'(INV_C[r * 3 + 1]) * DW'(rot_i_reg);
                inv_prod_reg[r * 3 + 2] <= DW'(INV_C[r * 3 + 2]) * DW'(rot_q_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: inverse sums, rounding, clamp to 0..255, output register.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] inv_sum [3];
    logic [VW-1:0]        inv_val [3];
    logic [7:0]           pix_next [3];
    logic [7:0]           pix_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            inv_sum[r] = EW'(inv_prod_reg[r * 3 + 0]) + EW'(inv_prod_reg[r * 3 + 1])
                       + EW'(inv_prod_reg[r * 3 + 2]) + HALF_INV;
            inv_val[r] = inv_sum[r][EW-1:F];
            if (inv_val[r][VW-1])
            begin
                pix_next[r] = 8'd0;
            end
            else if (|inv_val[r][VW-2:F+8])
            begin
                pix_next[r] = 8'd255;
            end
            else
            begin
                pix_next[r] = inv_val[r][F+7:F];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            for (int r = 0; r < 3; r++)
            begin
                pix_reg[r] <= pix_next[r];
            end
        end
    end

    assign red_out   = pix_reg[0];
    assign green_out = pix_reg[1];
    assign blue_out  = pix_reg[2];

endmodule

// ===== src/yhr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIQ hue rotation port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module yhr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [7:0]                        red_in,
    input logic [7:0]                        green_in,
    input logic [7:0]                        blue_in,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [7:0]                        red_out,
    input logic [7:0]                        green_out,
    input logic [7:0]                        blue_out,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [yhr_pkg::APB_ADDR_W-1:0]    paddr,
    input logic [yhr_pkg::APB_DATA_W-1:0]    pwdata,
    input logic [yhr_pkg::APB_DATA_W-1:0]    prdata,
    input logic                              pready
);

    // A stalled result keeps its transaction unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("output transaction changed while stalled");

    // A result appearing after an empty output comes from a transaction
    // accepted at the input and carried through every stage without waiting, since bubbles never stall.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 5))
        else $error("output appeared without a matching input transaction");

    // A written register reads back sign-extended from its low 16 bits.
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(psel && penable && pwrite) && psel && !pwrite && paddr == $past(paddr)
            |-> prdata[15:0] == $past(pwdata[15:0])
                && prdata[31:16] == {16{$past(pwdata[15])}})
        else $error("register readback mismatch");

    // The slave never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during a transfer");

endmodule

bind yiq_hue_rotate_pixel_top yhr_checker u_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue rotation pixel pipeline testbench
// Drives RGB888 pixels into the YIQ hue rotation pipeline under random and
// directed angle settings, predicts every rotated pixel in fixed point and
// compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // One row of the directed table. When "typed" is set the expected pixel
    // is taken from the row itself, otherwise the predictor supplies it.
    typedef struct packed {
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
        pixel_t             px;
        bit                 typed;
        pixel_t             want;
    } dir_row_t;

    localparam int FRAC       = 14;   // coefficient fraction bits of the DUT default
    localparam int LAT_SLACK  = 8;    // five pipeline stages plus margin
    localparam int LONG_HOLD  = 300;  // receiver hold-off used to fill the pipeline
    localparam int MAX_PRINTS = 40;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic [7:0]                         red_in    = 8'd0;
    logic [7:0]                         green_in  = 8'd0;
    logic [7:0]                         blue_in   = 8'd0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [7:0]                         red_out;
    logic [7:0]                         green_out;
    logic [7:0]                         blue_out;
    logic                               psel      = 1'b0;
    logic                               penable   = 1'b0;
    logic                               pwrite    = 1'b0;
    logic [yhr_pkg::APB_ADDR_W-1:0]     paddr     = '0;
    logic [yhr_pkg::APB_DATA_W-1:0]     pwdata    = '0;
    logic [yhr_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    // Shadow copy of the angle registers, as the predictor sees them.
    logic signed [15:0]     cos_shadow = 16'sd16384;
    logic signed [15:0]     sin_shadow = 16'sd0;

    pixel_t                 pending_pixels [$];

    int                     n_errors    = 0;
    int                     n_sent      = 0;
    int                     n_checked   = 0;
    int                     n_settings  = 0;
    int                     n_in_stalls = 0;

    // Both sides idle at random unless this is set. Long hold-off requests
    // are counted by the stimulus and served one by one by the receiver.
    bit                     no_idle     = 1'b0;
    int                     n_hold_req  = 0;
    int                     n_hold_done = 0;

    dir_row_t               dir_rows [0:31];
    int                     n_dir = 0;

    yiq_hue_rotate_pixel_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point hue rotation predictor
    // ------------------------------------------------------------------------

    // Quantizes a coefficient given in thousandths to FRAC fraction bits,
    // rounding ties away from zero: one extra bit of precision, add one, drop it.
    function automatic longint quant_coef(input int milli);
        longint mag;
        longint q;
        mag = (milli < 0) ? -longint'(milli) : longint'(milli);
        q   = (((mag <<< (FRAC + 1)) / 1000) + 1) >>> 1;
        return (milli < 0) ? -q : q;
    endfunction

    // Adds half an LSB and floors; longint is signed so >>> floors negatives.
    function automatic longint round_half_up(input longint x, input int sh);
        return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Rounds the inverse-matrix sum back to FRAC bits, clamps negatives to
    // zero, truncates to the integer part and saturates at 255.
    function automatic logic [7:0] to_channel(input longint acc);
        longint v;
        longint ip;
        v = round_half_up(acc, FRAC);
        if (v < 0)
            return 8'd0;
        ip = v >>> FRAC;
        return (ip > 255) ? 8'd255 : ip[7:0];
    endfunction

    function automatic pixel_t rotate_hue(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b,
                                          input logic signed [15:0] c,
                                          input logic signed [15:0] s);
        longint rr, gg, bb, cl, sl;
        longint y, i, q, i_rot, q_rot;
        pixel_t px;
        rr = longint'(r);
        gg = longint'(g);
        bb = longint'(b);
        cl = c;
        sl = s;
        // Forward matrix: RGB to YIQ, exact sums with FRAC fraction bits.
        y = quant_coef(299) * rr + quant_coef(587) * gg + quant_coef(114) * bb;
        i = quant_coef(596) * rr + quant_coef(-274) * gg + quant_coef(-321) * bb;
        q = quant_coef(211) * rr + quant_coef(-523) * gg + quant_coef(311) * bb;
        // Rotation of the chroma pair by the Q1.14 angle.
        i_rot = round_half_up(cl * i - sl * q, yhr_pkg::ANGLE_FRAC_BITS);
        q_rot = round_half_up(sl * i + cl * q, yhr_pkg::ANGLE_FRAC_BITS);
        // Inverse matrix back to RGB.
        px.r = to_channel(quant_coef(1000) * y + quant_coef(956) * i_rot
                          + quant_coef(621) * q_rot);
        px.g = to_channel(quant_coef(1000) * y + quant_coef(-272) * i_rot
                          + quant_coef(-647) * q_rot);
        px.b = to_channel(quant_coef(1000) * y + quant_coef(-1107) * i_rot
                          + quant_coef(1705) * q_rot);
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port access
    // ------------------------------------------------------------------------

    // Each access starts with its own clock edge so that psel never gets two
    // assignments in one time step when accesses follow each other.
    task automatic apb_write(input logic reg_idx, input logic [15:0] value);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        // The upper half carries random bits; only the low 16 bits count.
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == yhr_pkg::REG_COS_ANGLE)
            cos_shadow = value;
        else
            sin_shadow = value;
    endtask

    task automatic apb_read_check(input logic reg_idx);
        logic [15:0] want;
        logic [15:0] got;
        want = (reg_idx == yhr_pkg::REG_COS_ANGLE) ? cos_shadow : sin_shadow;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      reg_idx, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Pixel input side
    // ------------------------------------------------------------------------

    function automatic int sender_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Offers one pixel after "gap" idle cycles and returns at the edge where
    // the transaction is accepted. Valid stays high across back-to-back
    // transactions, so it is only lowered when an idle gap follows.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input bit typed,
                              input pixel_t typed_px, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do @(posedge clk); while (!in_ready);
        // Accepted at this edge: the angle shadow is stable here because
        // registers only change while the pipeline is empty.
        if (typed)
            pending_pixels.push_back(typed_px);
        else
            pending_pixels.push_back(rotate_hue(r, g, b, cos_shadow, sin_shadow));
        n_sent++;
    endtask

    // Stops offering pixels and waits until every predicted pixel has come out.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Registers are written only with the pipeline empty, then read back.
    task automatic program_angle(input logic [15:0] c, input logic [15:0] s);
        wait_all_results();
        repeat (LAT_SLACK) @(posedge clk);
        apb_write(yhr_pkg::REG_COS_ANGLE, c);
        apb_write(yhr_pkg::REG_SIN_ANGLE, s);
        apb_read_check(yhr_pkg::REG_COS_ANGLE);
        apb_read_check(yhr_pkg::REG_SIN_ANGLE);
        n_settings++;
    endtask

    task automatic add_row(input int cv, input int sv, input int r, input int g,
                           input int b, input bit typed, input int er, input int eg,
                           input int eb);
        dir_rows[n_dir].cos_v  = 16'(cv);
        dir_rows[n_dir].sin_v  = 16'(sv);
        dir_rows[n_dir].px.r   = 8'(r);
        dir_rows[n_dir].px.g   = 8'(g);
        dir_rows[n_dir].px.b   = 8'(b);
        dir_rows[n_dir].typed  = typed;
        dir_rows[n_dir].want.r = 8'(er);
        dir_rows[n_dir].want.g = 8'(eg);
        dir_rows[n_dir].want.b = 8'(eb);
        n_dir++;
    endtask

    // Random angle register value: either a proper Q1.14 sine or cosine in
    // -1.0..+1.0, or any 16-bit pattern, which the block takes as given.
    function automatic logic [15:0] random_angle(input bit full);
        int v;
        if (full)
            v = $urandom_range(0, 65535);
        else
            v = $urandom_range(0, 32768) - 16384;
        return v[15:0];
    endfunction

    // Random pixel with some weight on saturated, gray and near-edge colors.
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        int kind;
        kind = $urandom_range(0, 9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case (kind)
            6: begin
                r = {8{r[0]}};
                g = {8{g[0]}};
                b = {8{b[0]}};
            end
            7: begin
                g = r;
                b = r;
            end
            8: begin
                r = r[7] ? {6'h3f, r[1:0]} : {6'h00, r[1:0]};
                g = g[7] ? {6'h3f, g[1:0]} : {6'h00, g[1:0]};
                b = b[7] ? {6'h3f, b[1:0]} : {6'h00, b[1:0]};
            end
            9: begin
                g = 8'd0;
                b = 8'd0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Pixel output side
    // ------------------------------------------------------------------------

    // For every result the receiver draws an idle time, holds ready low for
    // it and then keeps ready high until one transaction has been taken.
    // A pending long hold-off request is served first, counted here in
    // cycles while the sender keeps offering pixels.
    initial
    begin : receiver
        int gap;
        wait (rst_n);
        forever
        begin
            if (n_hold_done != n_hold_req) begin
                n_hold_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Every output transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %0d,%0d,%0d",
                                          red_out, green_out, blue_out));
            end
            else begin
                want = pending_pixels.pop_front();
                n_checked++;
                if (red_out !== want.r)
                    report_mismatch($sformatf("result %0d red_out %0d, expected %0d",
                                              n_checked, red_out, want.r));
                if (green_out !== want.g)
                    report_mismatch($sformatf("result %0d green_out %0d, expected %0d",
                                              n_checked, green_out, want.g));
                if (blue_out !== want.b)
                    report_mismatch($sformatf("result %0d blue_out %0d, expected %0d",
                                              n_checked, blue_out, want.b));
            end
        end
    end

    // Counts cycles in which the pipeline pushed back on an offered pixel.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
            n_in_stalls++;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        int          k;
        int          phase;
        int          gap;
        logic [7:0]  r, g, b;
        logic [15:0] c, s;
        pixel_t      none;

        none = '0;

        // Reset is held low from time zero and released on a clock edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset values of both registers must read back.
        apb_read_check(yhr_pkg::REG_COS_ANGLE);
        apb_read_check(yhr_pkg::REG_SIN_ANGLE);

        // Directed table. Typed results are the obvious ones: black stays
        // black under any angle, and with cos = sin = 0 the chroma vanishes
        // so every channel equals the integer part of the luma.
        // Reset angle (identity rotation), primaries and alternating bits.
        add_row(16384, 0, 0, 0, 0, 1'b1, 0, 0, 0);
        add_row(16384, 0, 255, 255, 255, 1'b0, 0, 0, 0);
        add_row(16384, 0, 255, 0, 0, 1'b0, 0, 0, 0);
        add_row(16384, 0, 0, 255, 0, 1'b0, 0, 0, 0);
        add_row(16384, 0, 0, 0, 255, 1'b0, 0, 0, 0);
        add_row(16384, 0, 170, 85, 170, 1'b0, 0, 0, 0);
        add_row(16384, 0, 85, 170, 85, 1'b0, 0, 0, 0);
        // Zero angle vector: pure luma.
        add_row(0, 0, 255, 255, 255, 1'b1, 255, 255, 255);
        add_row(0, 0, 128, 64, 32, 1'b1, 79, 79, 79);
        add_row(0, 0, 0, 0, 0, 1'b1, 0, 0, 0);
        // Half turn, then plus and minus a quarter turn.
        add_row(-16384, 0, 255, 0, 0, 1'b0, 0, 0, 0);
        add_row(-16384, 0, 0, 255, 255, 1'b0, 0, 0, 0);
        add_row(-16384, 0, 200, 100, 50, 1'b0, 0, 0, 0);
        add_row(0, 16384, 255, 0, 0, 1'b0, 0, 0, 0);
        add_row(0, 16384, 0, 0, 255, 1'b0, 0, 0, 0);
        add_row(0, -16384, 0, 255, 0, 1'b0, 0, 0, 0);
        add_row(0, -16384, 30, 200, 90, 1'b0, 0, 0, 0);
        // Register values beyond +-1.0 are used as given; outputs saturate.
        add_row(32767, -32768, 255, 0, 0, 1'b0, 0, 0, 0);
        add_row(32767, -32768, 0, 255, 255, 1'b0, 0, 0, 0);
        add_row(32767, -32768, 0, 0, 0, 1'b1, 0, 0, 0);
        add_row(-32768, 32767, 0, 0, 255, 1'b0, 0, 0, 0);
        add_row(-32768, 32767, 255, 255, 0, 1'b0, 0, 0, 0);
        // Forty-five degrees.
        add_row(11585, 11585, 255, 128, 0, 1'b0, 0, 0, 0);
        add_row(11585, 11585, 1, 254, 127, 1'b0, 0, 0, 0);

        for (k = 0; k < n_dir; k++) begin
            if (dir_rows[k].cos_v != cos_shadow || dir_rows[k].sin_v != sin_shadow)
                program_angle(dir_rows[k].cos_v, dir_rows[k].sin_v);
            send_pixel(dir_rows[k].px.r, dir_rows[k].px.g, dir_rows[k].px.b,
                       dir_rows[k].typed, dir_rows[k].want, sender_gap());
        end

        // Random part: twelve phases, each with its own angle setting.
        for (phase = 0; phase < 12; phase++) begin
            case (phase)
                0:       begin c = 16'h8000; s = 16'h8000; end
                1:       begin c = 16'h7fff; s = 16'h7fff; end
                6:       begin c = 16'd16384; s = 16'd0; end
                9:       begin c = 16'h0000; s = 16'hc000; end
                default: begin
                    c = random_angle(phase[0]);
                    s = random_angle(phase[0]);
                end
            endcase
            program_angle(c, s);
            // Phase 4 runs both sides at full rate with no idling at all.
            no_idle = (phase == 4);
            for (k = 0; k < 102; k++) begin
                // Phase 2: the receiver holds off for a long stretch while the
                // sender streams back to back, so the pipeline fills and
                // pushes back on its input.
                if (phase == 2 && k == 10)
                    n_hold_req++;
                // Phase 7: the sender pauses mid-stream until all results are out.
                if (phase == 7 && k == 50)
                    wait_all_results();
                gap = (phase == 2 && k >= 10 && k < 80) ? 0 : sender_gap();
                random_pixel(r, g, b);
                send_pixel(r, g, b, 1'b0, none, gap);
            end
        end
        no_idle = 1'b0;

        // Drain, then let the pipeline run a little longer so that any
        // spurious extra output would still be caught.
        wait_all_results();
        repeat (LAT_SLACK * 4) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d predicted pixels never came out",
                                      pending_pixels.size()));

        $display("summary: %0d pixels sent, %0d results checked over %0d angle settings",
                 n_sent, n_checked, n_settings);
        $display("summary: input backpressure on %0d cycles, %0d mismatches",
                 n_in_stalls, n_errors);
        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("watchdog expired with %0d results outstanding", pending_pixels.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/yhr_pkg.sv
src/yhr_apb_regs.sv
src/yiq_hue_rotate_pixel_top.sv
src/yhr_checker.sv
verif/tb_top.sv
